>>> design/crc16fr_pkg.sv
// ----------------------------------------------------------------------------
// crc16fr_pkg
// Types, status codes and the CRC-16/MODBUS byte update for the frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package crc16fr_pkg;

    localparam int unsigned CFG_INDEX_W = 8;
    localparam int unsigned CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_TIMEOUT = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_PDU_LEN   = 8'd1;

    localparam logic [7:0] FRAME_TIMEOUT_RST = 8'd2;
    localparam logic [7:0] MAX_PDU_LEN_RST   = 8'd15;

    localparam logic [7:0]  HEAD_FIRST  = 8'h4D;
    localparam logic [7:0]  HEAD_SECOND = 8'h4C;
    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [15:0] CRC_POLY    = 16'hA001;

    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic [2:0] ST_BUSY         = 3'd0;
    localparam logic [2:0] ST_PAYLOAD      = 3'd1;
    localparam logic [2:0] ST_GOOD         = 3'd2;
    localparam logic [2:0] ST_BAD_HEADER   = 3'd3;
    localparam logic [2:0] ST_BAD_LENGTH   = 3'd4;
    localparam logic [2:0] ST_CRC_MISMATCH = 3'd5;
    localparam logic [2:0] ST_TIMEOUT      = 3'd6;

    typedef struct packed {
        logic       command;
        logic [7:0] data_byte;
    } rx_item_t;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] payload_byte;
        logic [7:0] frame_length;
    } rx_result_t;

    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

>>> design/crc16_frame_receiver_unit.sv
// ----------------------------------------------------------------------------
// crc16_frame_receiver_unit
// Picks 'M' 'L' LEN payload CRC frames out of a byte and tick stream and
// checks them against CRC-16/MODBUS.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one beat per received byte (command 0) or timer tick
//   (command 1). m_ channel: exactly one result beat per input beat, in order:
//   busy, payload byte passed through, or a frame verdict.
//   cfg channel: register index 0 is frame_timeout, 1 is max_pdu_len; other
//   indexes are dropped. cfg_ready is always high; write only while idle.
//   Each result is registered (into the skid register while one waits).
//   Throughput: one beat per cycle while s_ready is high. The frame state
//   and CRC byte updates sit between the input handshake and result register.
//   A two-entry output stage (result register plus skid register) lets one
//   more beat in while a result waits; s_ready falls only when both are full.
//   Reset: hunts for a header, CRC register at 0xFFFF, timeout 2 ticks,
//   max payload 15 bytes, no result pending.
//   Receiver stall: m_data holds until taken; s_ready drops once the skid
//   register is occupied and rises again as the stage drains.
// ----------------------------------------------------------------------------
`default_nettype none

module crc16_frame_receiver_unit
    import crc16fr_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output      logic                   s_ready,
    input  wire rx_item_t               s_data,
    output      logic                   m_valid,
    input  wire logic                   m_ready,
    output      rx_result_t             m_data,
    input  wire logic                   cfg_valid,
    output      logic                   cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam logic [1:0] PH_HUNT    = 2'd0;
    localparam logic [1:0] PH_PAYLOAD = 2'd1;
    localparam logic [1:0] PH_CRC     = 2'd2;

    logic [7:0]  frame_timeout_reg;
    logic [7:0]  max_pdu_len_reg;

    logic [1:0]  phase_reg,          phase_next;
    logic [7:0]  byte_count_reg,     byte_count_next;
    logic [7:0]  payload_length_reg, payload_length_next;
    logic [15:0] crc_reg,            crc_next;
    logic [7:0]  first_head_reg,     first_head_next;
    logic [7:0]  second_head_reg,    second_head_next;
    logic [7:0]  first_crc_reg,      first_crc_next;
    logic [7:0]  idle_ticks_reg,     idle_ticks_next;

    logic        m_valid_reg;
    rx_result_t  m_data_reg;
    logic        skid_valid_reg;
    rx_result_t  skid_data_reg;

    rx_result_t  result;
    logic        frame_clear;
    logic        in_beat;
    logic        out_free;
    logic [15:0] crc_byte;
    logic [7:0]  count_inc;
    logic [7:0]  ticks_inc;

    assign s_ready   = !skid_valid_reg;
    assign in_beat   = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign cfg_ready = 1'b1;

    assign crc_byte  = crc_update(crc_reg, s_data.data_byte);
    assign count_inc = byte_count_reg + 8'd1;
    assign ticks_inc = idle_ticks_reg + 8'd1;

    always_comb begin
        phase_next          = phase_reg;
        byte_count_next     = byte_count_reg;
        payload_length_next = payload_length_reg;
        crc_next            = crc_reg;
        first_head_next     = first_head_reg;
        second_head_next    = second_head_reg;
        first_crc_next      = first_crc_reg;
        idle_ticks_next     = idle_ticks_reg;
        result              = '0;
        frame_clear         = 1'b0;

        if (!(phase_reg inside {PH_HUNT, PH_PAYLOAD, PH_CRC})) begin
            frame_clear = 1'b1;
        end else if (s_data.command == CMD_TICK) begin
            if (phase_reg != PH_HUNT) begin
                idle_ticks_next = ticks_inc;
                if (ticks_inc >= frame_timeout_reg) begin
                    result.status = ST_TIMEOUT;
                    frame_clear   = 1'b1;
                end
            end
        end else begin
            case (phase_reg)
                PH_HUNT: begin
                    crc_next = crc_byte;
                    if (byte_count_reg == 8'd0) begin
                        first_head_next = s_data.data_byte;
                        byte_count_next = 8'd1;
                    end else if (byte_count_reg == 8'd1) begin
                        second_head_next = s_data.data_byte;
                        byte_count_next  = 8'd2;
                    end else if (first_head_reg != HEAD_FIRST
                                 || second_head_reg != HEAD_SECOND) begin
                        result.status = ST_BAD_HEADER;
                        frame_clear   = 1'b1;
                    end else if (s_data.data_byte == 8'd0
                                 || s_data.data_byte > max_pdu_len_reg) begin
                        result.status = ST_BAD_LENGTH;
                        frame_clear   = 1'b1;
                    end else begin
                        payload_length_next = s_data.data_byte;
                        byte_count_next     = 8'd0;
                        idle_ticks_next     = 8'd0;
                        phase_next          = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    idle_ticks_next     = 8'd0;
                    crc_next            = crc_byte;
                    result.status       = ST_PAYLOAD;
                    result.payload_byte = s_data.data_byte;
                    if (count_inc >= payload_length_reg) begin
                        byte_count_next = 8'd0;
                        phase_next      = PH_CRC;
                    end else begin
                        byte_count_next = count_inc;
                    end
                end
                default: begin
                    idle_ticks_next = 8'd0;
                    if (byte_count_reg == 8'd0) begin
                        first_crc_next  = s_data.data_byte;
                        byte_count_next = 8'd1;
                    end else begin
                        if (first_crc_reg == crc_reg[15:8]
                            && s_data.data_byte == crc_reg[7:0]) begin
                            result.status       = ST_GOOD;
                            result.frame_length = payload_length_reg;
                        end else begin
                            result.status = ST_CRC_MISMATCH;
                        end
                        frame_clear = 1'b1;
                    end
                end
            endcase
        end

        if (frame_clear) begin
            phase_next          = PH_HUNT;
            byte_count_next     = 8'd0;
            payload_length_next = 8'd0;
            crc_next            = CRC_INIT;
            first_head_next     = 8'd0;
            second_head_next    = 8'd0;
            first_crc_next      = 8'd0;
            idle_ticks_next     = 8'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_timeout_reg <= FRAME_TIMEOUT_RST;
            max_pdu_len_reg   <= MAX_PDU_LEN_RST;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == CFG_FRAME_TIMEOUT) begin
                frame_timeout_reg <= cfg_data;
            end else if (cfg_index == CFG_MAX_PDU_LEN) begin
                max_pdu_len_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg          <= PH_HUNT;
            byte_count_reg     <= 8'd0;
            payload_length_reg <= 8'd0;
            crc_reg            <= CRC_INIT;
            first_head_reg     <= 8'd0;
            second_head_reg    <= 8'd0;
            first_crc_reg      <= 8'd0;
            idle_ticks_reg     <= 8'd0;
        end else if (in_beat) begin
            phase_reg          <= phase_next;
            byte_count_reg     <= byte_count_next;
            payload_length_reg <= payload_length_next;
            crc_reg            <= crc_next;
            first_head_reg     <= first_head_next;
            second_head_reg    <= second_head_next;
            first_crc_reg      <= first_crc_next;
            idle_ticks_reg     <= idle_ticks_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_free) begin
            if (skid_valid_reg) begin
                m_valid_reg    <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                m_valid_reg <= in_beat;
            end
        end else if (in_beat) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            if (skid_valid_reg) begin
                m_data_reg <= skid_data_reg;
            end else if (in_beat) begin
                m_data_reg <= result;
            end
        end else if (in_beat) begin
            skid_data_reg <= result;
        end
    end

endmodule

`default_nettype wire

>>> design/crc16fr_checker.sv
// ----------------------------------------------------------------------------
// crc16fr_checker
// Port-level checks on the frame receiver's result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module crc16fr_checker
    import crc16fr_pkg::*;
(
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_valid,
    input wire logic       s_ready,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire rx_result_t m_data
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid straight after reset");

    a_beat_yields_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid)
        else $error("accepted beat produced no result");

    a_length_only_good: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != ST_GOOD |-> m_data.frame_length == 8'd0)
        else $error("frame length outside a good verdict");

    a_payload_only_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != ST_PAYLOAD |-> m_data.payload_byte == 8'd0)
        else $error("payload byte outside a payload beat");

endmodule

bind crc16_frame_receiver_unit crc16fr_checker u_crc16fr_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for crc16_frame_receiver_unit. A short table of directed
// beats covers header, length, CRC and timeout verdicts; randomised frame
// traffic then runs under several limit settings. Every result beat is
// compared field by field with its table entry or with an in-bench frame model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import crc16fr_pkg::*;

    localparam int STALL_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int TAIL_CYCLES     = 8;
    localparam int MAX_REPORTS     = 10;
    localparam int N_SETTINGS      = 7;
    localparam int PHASE_BEATS     = 275;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_IDX = 8'd2;

    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_CRC     = 2'd2
    } frame_phase_e;

    typedef enum logic [1:0] {
        FILL_NONE,
        FILL_CRC_HI,
        FILL_CRC_LO,
        FILL_CRC_LO_BAD
    } byte_fill_e;

    typedef struct packed {
        byte_fill_e fill;
        rx_item_t   item;
        logic       typed;
        rx_result_t res;
    } dir_row_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_valid   = 1'b0;
    logic                   s_ready;
    rx_item_t               s_data    = '0;
    logic                   m_valid;
    logic                   m_ready   = 1'b0;
    rx_result_t             m_data;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    frame_phase_e frm_phase;
    logic [7:0]   frm_count;
    logic [7:0]   frm_len;
    logic [15:0]  frm_crc;
    logic [7:0]   frm_head0;
    logic [7:0]   frm_head1;
    logic [7:0]   frm_crc_hi;
    logic [7:0]   frm_idle;
    logic [7:0]   lim_timeout;
    logic [7:0]   lim_max_len;

    rx_result_t due_results[$];
    dir_row_t   dir_rows[$];
    int         fault_count  = 0;
    int         sent_items   = 0;
    int         quiet_cycles = 0;
    int         tx_calm      = 0;
    int         rx_calm      = 0;
    logic       stall_req    = 1'b0;

    crc16_frame_receiver_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    function automatic logic [15:0] modbus_crc_next(input logic [15:0] crc,
                                                    input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 0; i < 8; i++) begin
            fb = c[0] ^ b[i];
            c  = c >> 1;
            if (fb) begin
                c = c ^ 16'hA001;
            end
        end
        return c;
    endfunction

    function automatic void clear_frame();
        frm_phase  = PH_HUNT;
        frm_count  = 8'd0;
        frm_len    = 8'd0;
        frm_crc    = 16'hFFFF;
        frm_head0  = 8'd0;
        frm_head1  = 8'd0;
        frm_crc_hi = 8'd0;
        frm_idle   = 8'd0;
    endfunction

    function automatic rx_result_t step_frame(input rx_item_t it);
        rx_result_t res;
        logic [7:0] b;
        res        = '0;
        res.status = ST_BUSY;
        b          = it.data_byte;
        if (it.command == CMD_TICK) begin
            if (frm_phase != PH_HUNT) begin
                frm_idle = frm_idle + 8'd1;
                if (frm_idle >= lim_timeout) begin
                    res.status = ST_TIMEOUT;
                    clear_frame();
                end
            end
        end else begin
            case (frm_phase)
                PH_HUNT: begin
                    frm_crc = modbus_crc_next(frm_crc, b);
                    if (frm_count == 8'd0) begin
                        frm_head0 = b;
                        frm_count = 8'd1;
                    end else if (frm_count == 8'd1) begin
                        frm_head1 = b;
                        frm_count = 8'd2;
                    end else if (frm_head0 != HEAD_FIRST || frm_head1 != HEAD_SECOND) begin
                        res.status = ST_BAD_HEADER;
                        clear_frame();
                    end else if (b == 8'd0 || b > lim_max_len) begin
                        res.status = ST_BAD_LENGTH;
                        clear_frame();
                    end else begin
                        frm_len   = b;
                        frm_count = 8'd0;
                        frm_idle  = 8'd0;
                        frm_phase = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    frm_idle         = 8'd0;
                    frm_crc          = modbus_crc_next(frm_crc, b);
                    res.status       = ST_PAYLOAD;
                    res.payload_byte = b;
                    frm_count        = frm_count + 8'd1;
                    if (frm_count >= frm_len) begin
                        frm_count = 8'd0;
                        frm_phase = PH_CRC;
                    end
                end
                PH_CRC: begin
                    frm_idle = 8'd0;
                    if (frm_count == 8'd0) begin
                        frm_crc_hi = b;
                        frm_count  = 8'd1;
                    end else begin
                        if (frm_crc_hi == frm_crc[15:8] && b == frm_crc[7:0]) begin
                            res.status       = ST_GOOD;
                            res.frame_length = frm_len;
                        end else begin
                            res.status = ST_CRC_MISMATCH;
                        end
                        clear_frame();
                    end
                end
                default: clear_frame();
            endcase
        end
        return res;
    endfunction

    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            calm = $urandom_range(30, 150);
            return 0;
        end
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic dir_row_t dir_row(input byte_fill_e f, input logic cmd,
                                         input logic [7:0] b, input logic typed,
                                         input logic [2:0] st, input logic [7:0] pay,
                                         input logic [7:0] flen);
        dir_row_t row;
        row.fill               = f;
        row.item.command       = cmd;
        row.item.data_byte     = b;
        row.typed              = typed;
        row.res.status         = st;
        row.res.payload_byte   = pay;
        row.res.frame_length   = flen;
        return row;
    endfunction

    task automatic send_beat(input rx_item_t it, input logic typed,
                             input rx_result_t typed_res);
        int         gap;
        rx_result_t predicted;
        gap = pick_gap(tx_calm);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (s_ready !== 1'b1) @(posedge aclk);
        predicted = step_frame(it);
        due_results.push_back(typed ? typed_res : predicted);
        sent_items++;
    endtask

    task automatic put_byte(input logic [7:0] b);
        rx_item_t it;
        it.command   = CMD_BYTE;
        it.data_byte = b;
        send_beat(it, 1'b0, '0);
    endtask

    task automatic put_tick();
        rx_item_t it;
        it.command   = CMD_TICK;
        it.data_byte = 8'($urandom_range(0, 255));
        send_beat(it, 1'b0, '0);
    endtask

    // pad the gap between bytes with ticks that stay under the timeout
    task automatic put_idle_ticks();
        int allowed;
        allowed = (lim_timeout > 8'd1) ? int'(lim_timeout) - 1 : 0;
        if (allowed > 4) allowed = 4;
        if (allowed > 0 && $urandom_range(0, 99) < 25) begin
            repeat ($urandom_range(1, allowed)) put_tick();
        end
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (cfg_ready !== 1'b1) @(posedge aclk);
        case (idx)
            CFG_FRAME_TIMEOUT: lim_timeout = val;
            CFG_MAX_PDU_LEN:   lim_max_len = val;
            default: ;
        endcase
    endtask

    task automatic set_limits(input logic [7:0] timeout, input logic [7:0] max_len,
                              input logic stray);
        s_valid <= 1'b0;
        while (due_results.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
        if (stray) begin
            write_reg(CFG_UNUSED_IDX, 8'($urandom_range(0, 255)));
        end
        write_reg(CFG_FRAME_TIMEOUT, timeout);
        write_reg(CFG_MAX_PDU_LEN, max_len);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_frame();
        int         kind;
        int         len;
        int         cut;
        int         k;
        logic [7:0] hi_mask;
        logic [7:0] lo_mask;
        kind    = $urandom_range(0, 99);
        hi_mask = 8'h00;
        lo_mask = 8'h00;
        // realign on a fresh header hunt
        while (frm_phase != PH_HUNT || frm_count != 8'd0) put_byte(8'($urandom_range(0, 255)));
        if (kind >= 92) begin
            repeat ($urandom_range(1, 12)) begin
                if ($urandom_range(0, 2) == 0) put_tick();
                else put_byte(8'($urandom_range(0, 255)));
            end
            return;
        end
        if (kind >= 86) begin
            put_byte(8'($urandom_range(0, 255)));
            put_byte(8'($urandom_range(0, 255)));
        end else begin
            put_byte(HEAD_FIRST);
            put_idle_ticks();
            put_byte(HEAD_SECOND);
        end
        if (kind >= 80 && kind < 86) begin
            if (lim_max_len == 8'd255 || $urandom_range(0, 1) == 0) len = 0;
            else len = $urandom_range(int'(lim_max_len) + 1, 255);
        end else if (lim_max_len == 8'd0) begin
            len = $urandom_range(0, 255);
        end else if ($urandom_range(0, 99) < 85) begin
            len = $urandom_range(1, (lim_max_len < 8'd8) ? int'(lim_max_len) : 8);
        end else begin
            len = $urandom_range(1, lim_max_len);
        end
        put_byte(len[7:0]);
        cut = (kind >= 70 && kind < 80) ? $urandom_range(0, len) : -1;
        k   = 0;
        while (frm_phase == PH_PAYLOAD) begin
            if (k == cut) break;
            put_idle_ticks();
            put_byte(8'($urandom_range(0, 255)));
            k++;
        end
        if (cut >= 0) begin
            while (frm_phase != PH_HUNT) put_tick();
            return;
        end
        if (frm_phase != PH_CRC) return;
        if (kind >= 60 && kind < 70) begin
            if ($urandom_range(0, 1) == 0) hi_mask = 8'($urandom_range(1, 255));
            else lo_mask = 8'($urandom_range(1, 255));
        end
        put_idle_ticks();
        put_byte(frm_crc[15:8] ^ hi_mask);
        put_idle_ticks();
        put_byte(frm_crc[7:0] ^ lo_mask);
    endtask

    always @(posedge aclk) begin : result_check
        rx_result_t want;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (due_results.size() == 0) begin
                fault_count++;
                if (fault_count <= MAX_REPORTS) begin
                    $display("%0t unexpected result beat: status %0d payload %02h length %0d",
                             $realtime, m_data.status, m_data.payload_byte,
                             m_data.frame_length);
                end
            end else begin
                want = due_results.pop_front();
                if (m_data.status !== want.status ||
                    m_data.payload_byte !== want.payload_byte ||
                    m_data.frame_length !== want.frame_length) begin
                    fault_count++;
                    if (fault_count <= MAX_REPORTS) begin
                        $display("%0t result mismatch: expected status %0d payload %02h length %0d, got status %0d payload %02h length %0d",
                                 $realtime, want.status, want.payload_byte,
                                 want.frame_length, m_data.status,
                                 m_data.payload_byte, m_data.frame_length);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial begin : result_sink
        int hold;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (stall_req) begin
                stall_req = 1'b0;
                m_ready <= 1'b0;
                repeat (STALL_CYCLES) @(posedge aclk);
            end
            hold = pick_gap(rx_calm);
            if (hold > 0) begin
                m_ready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    initial begin : stimulus
        rx_item_t   it;
        logic [7:0] set_timeout [N_SETTINGS];
        logic [7:0] set_max_len [N_SETTINGS];
        int         phase_end;

        lim_timeout = FRAME_TIMEOUT_RST;
        lim_max_len = MAX_PDU_LEN_RST;
        clear_frame();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        set_limits(FRAME_TIMEOUT_RST, MAX_PDU_LEN_RST, 1'b1);

        dir_rows.push_back(dir_row(FILL_NONE, CMD_TICK, 8'h00, 1'b1, ST_BUSY, 8'h00, 8'd0));
        dir_rows.push_back(dir_row(FILL_NONE, CMD_BYTE, HEAD_FIRST, 1'b1, ST_BUSY, 8'h00, 8'd0));
        dir_rows.push_back(dir_row(FILL_NONE, CMD_BYTE, HEAD_SECOND, 1'b1, ST_BUSY, 8'h00, 8'd0));
        dir_rows.push_back(dir_row(FILL_NONE, CMD_BYTE, 8'h00, 1'b1, ST_BAD_LENGTH, 8'h00, 8'd0));
        dir_rows.push_back(dir_row(FILL_NONE, CMD_BYTE, 8'hFF, 1'b1, ST_BUSY, 8'h00, 8'd0));
        dir_rows.push_back(dir_row(FILL_NONE, CMD_BYTE, 8'h00, 1'b1, ST_BUSY, 8'h00, 8'd0));
        dir_rows.push_back(dir_row(FILL_NONE, CMD_BYTE, HEAD_SECOND, 1'b1, ST_BAD_HEADER,
                                   8'h00, 8'd0));
        dir_rows.push_back(dir_row(FILL_NONE, CMD_BYTE, HEAD_FIRST, 1'b1, ST_BUSY, 8'h00, 8'd0));
        dir_rows.push_back(dir_row(FILL_NONE, CMD_BYTE, HEAD_SECOND, 1'b1, ST_BUSY, 8'h00, 8'd0));
        dir_rows.push_back(dir_row(FILL_NONE, CMD_BYTE, 8'd16, 1'b1, ST_BAD_LENGTH, 8'h00, 8'd0));
        dir_rows.push_back(dir_row(FILL_NONE, CMD_BYTE, HEAD_FIRST, 1'b1, ST_BUSY, 8'h00, 8'd0));
        dir_rows.push_back(dir_row(FILL_NONE, CMD_BYTE, HEAD_SECOND, 1'b1, ST_BUSY, 8'h00, 8'd0));
        dir_rows.push_back(dir_row(FILL_NONE, CMD_BYTE, 8'd1, 1'b1, ST_BUSY, 8'h00, 8'd0));
        dir_rows.push_back(dir_row(FILL_NONE, CMD_BYTE, 8'hFF, 1'b1, ST_PAYLOAD, 8'hFF, 8'd0));
        dir_rows.push_back(dir_row(FILL_CRC_HI, CMD_BYTE, 8'h00, 1'b0, ST_BUSY, 8'h00, 8'd0));
        dir_rows.push_back(dir_row(FILL_CRC_LO, CMD_BYTE, 8'h00, 1'b1, ST_GOOD, 8'h00, 8'd1));
        dir_rows.push_back(dir_row(FILL_NONE, CMD_BYTE, HEAD_FIRST, 1'b1, ST_BUSY, 8'h00, 8'd0));
        dir_rows.push_back(dir_row(FILL_NONE, CMD_BYTE, HEAD_SECOND, 1'b1, ST_BUSY, 8'h00, 8'd0));
        dir_rows.push_back(dir_row(FILL_NONE, CMD_BYTE, 8'd1, 1'b1, ST_BUSY, 8'h00, 8'd0));
        dir_rows.push_back(dir_row(FILL_NONE, CMD_BYTE, 8'h00, 1'b1, ST_PAYLOAD, 8'h00, 8'd0));
        dir_rows.push_back(dir_row(FILL_CRC_HI, CMD_BYTE, 8'h00, 1'b0, ST_BUSY, 8'h00, 8'd0));
        dir_rows.push_back(dir_row(FILL_CRC_LO_BAD, CMD_BYTE, 8'h00, 1'b1, ST_CRC_MISMATCH,
                                   8'h00, 8'd0));
        dir_rows.push_back(dir_row(FILL_NONE, CMD_BYTE, HEAD_FIRST, 1'b1, ST_BUSY, 8'h00, 8'd0));
        dir_rows.push_back(dir_row(FILL_NONE, CMD_BYTE, HEAD_SECOND, 1'b1, ST_BUSY, 8'h00, 8'd0));
        dir_rows.push_back(dir_row(FILL_NONE, CMD_BYTE, 8'd1, 1'b1, ST_BUSY, 8'h00, 8'd0));
        dir_rows.push_back(dir_row(FILL_NONE, CMD_TICK, 8'hFF, 1'b1, ST_BUSY, 8'h00, 8'd0));
        dir_rows.push_back(dir_row(FILL_NONE, CMD_TICK, 8'h00, 1'b1, ST_TIMEOUT, 8'h00, 8'd0));

        foreach (dir_rows[i]) begin
            it = dir_rows[i].item;
            case (dir_rows[i].fill)
                FILL_CRC_HI:     it.data_byte = frm_crc[15:8];
                FILL_CRC_LO:     it.data_byte = frm_crc[7:0];
                FILL_CRC_LO_BAD: it.data_byte = ~frm_crc[7:0];
                default: ;
            endcase
            send_beat(it, dir_rows[i].typed, dir_rows[i].res);
        end

        set_timeout = '{8'd2, 8'd1, 8'd255, 8'd0, 8'd5, 8'd0, 8'd0};
        set_max_len = '{8'd15, 8'd1, 8'd255, 8'd0, 8'd8, 8'd0, 8'd0};
        set_timeout[5] = 8'($urandom_range(1, 255));
        set_max_len[5] = 8'($urandom_range(1, 255));
        set_timeout[6] = 8'($urandom_range(1, 6));
        set_max_len[6] = 8'($urandom_range(1, 32));

        for (int p = 0; p < N_SETTINGS; p++) begin
            set_limits(set_timeout[p], set_max_len[p], 1'b0);
            phase_end = sent_items + PHASE_BEATS;
            if (p == 1) stall_req = 1'b1;
            while (sent_items < phase_end) send_frame();
        end

        s_valid <= 1'b0;
        while (due_results.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fault_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
